// ----- design/block_average_downscale_assert.svh -----
// Assertion macros for the block average downscaler.
`ifndef BLOCK_AVERAGE_DOWNSCALE_ASSERT_SVH
`define BLOCK_AVERAGE_DOWNSCALE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define BAD_ASSERT_IMPLY(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// Check that cons holds in the cycle after ante.
`define BAD_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define BAD_ASSERT_IMPLY(label, ck, rn, ante, cons)
`define BAD_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

// ----- design/bad_pkg.sv -----
package bad_pkg;

	// Limits fixed by the register and field widths
	localparam int MAX_ICON_COLUMNS  = 256;
	localparam int MAX_SOURCE_SIDE   = 4096;
	localparam int MAX_ICON_ROWS     = 4096;
	localparam int SUM_WIDTH_DEFAULT = 32;

	localparam int DIM_W  = 13;
	localparam int ICW_W  = 9;
	localparam int POS_W  = 12;
	localparam int COL_W  = 8;
	localparam int AREA_W = 25;
	localparam int PIX_W  = 8;

	// Result queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int LVL_W   = $clog2(Q_DEPTH + 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLUMNS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ICON_COLUMNS   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ICON_ROWS      = 8'd3;

	// Frame geometry, clamped registers plus derived block sizes
	typedef struct packed {
		logic [DIM_W-1:0]  scols;
		logic [DIM_W-1:0]  srows;
		logic [ICW_W-1:0]  icols;
		logic [DIM_W-1:0]  irows;
		logic [DIM_W-1:0]  bw;
		logic [DIM_W-1:0]  bh;
		logic [DIM_W-1:0]  lim_x;
		logic [DIM_W-1:0]  lim_y;
		logic [AREA_W-1:0] area;
	} geom_t;

	// Position tag of one finished block
	typedef struct packed {
		logic             done;
		logic [COL_W-1:0] col;
		logic [POS_W-1:0] row;
	} blk_tag_t;

	localparam int TAG_W = $bits(blk_tag_t);

endpackage

// ----- design/bad_setup.sv -----
module bad_setup import bad_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	output geom_t                geom,
	output logic                 geom_ok
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_DIV,
		S_QUOT,
		S_MULX,
		S_MULY,
		S_MULA,
		S_READY
	} state_t;

	state_t state_q;

	logic [DIM_W-1:0]  src_cols_q, src_rows_q, icon_rows_q;
	logic [ICW_W-1:0]  icon_cols_q;
	logic [DIM_W-1:0]  nx_q, ny_q, rx_q, ry_q;
	logic [3:0]        cnt_q;
	logic [DIM_W-1:0]  bw_q, bh_q, lim_x_q, lim_y_q;
	logic [AREA_W-1:0] area_q;

	logic [DIM_W-1:0]  scols, srows, irows;
	logic [ICW_W-1:0]  icols;
	logic [DIM_W:0]    tx, ty, dx, dy, dfx, dfy;
	logic              gex, gey;
	logic [21:0]       prod_x;
	logic [25:0]       prod_y, prod_a;

	// Clamp oversized register values
	always_comb begin
		scols = (src_cols_q > DIM_W'(MAX_SOURCE_SIDE)) ? DIM_W'(MAX_SOURCE_SIDE) : src_cols_q;
		srows = (src_rows_q > DIM_W'(MAX_SOURCE_SIDE)) ? DIM_W'(MAX_SOURCE_SIDE) : src_rows_q;
		icols = (icon_cols_q > ICW_W'(MAX_ICON_COLUMNS)) ? ICW_W'(MAX_ICON_COLUMNS)
			: icon_cols_q;
		irows = (icon_rows_q > DIM_W'(MAX_ICON_ROWS)) ? DIM_W'(MAX_ICON_ROWS) : icon_rows_q;
	end

	// One restoring step for each of the two block size divisions
	always_comb begin
		tx  = {rx_q, nx_q[DIM_W-1]};
		ty  = {ry_q, ny_q[DIM_W-1]};
		dx  = {{(DIM_W+1-ICW_W){1'b0}}, icols};
		dy  = {1'b0, irows};
		gex = tx >= dx;
		gey = ty >= dy;
		dfx = tx - dx;
		dfy = ty - dy;
	end

	assign prod_x = bw_q * icols;
	assign prod_y = bh_q * irows;
	assign prod_a = bw_q * bh_q;

	// Hold registers, then derive block sizes, limits and area
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cols_q  <= DIM_W'(640);
			src_rows_q  <= DIM_W'(480);
			icon_cols_q <= ICW_W'(64);
			icon_rows_q <= DIM_W'(48);
			state_q     <= S_LOAD;
			nx_q        <= '0;
			ny_q        <= '0;
			rx_q        <= '0;
			ry_q        <= '0;
			cnt_q       <= '0;
			bw_q        <= '0;
			bh_q        <= '0;
			lim_x_q     <= '0;
			lim_y_q     <= '0;
			area_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SOURCE_COLUMNS: src_cols_q  <= cfg_data;
				REG_SOURCE_ROWS:    src_rows_q  <= cfg_data;
				REG_ICON_COLUMNS:   icon_cols_q <= cfg_data[ICW_W-1:0];
				REG_ICON_ROWS:      icon_rows_q <= cfg_data;
				default: ;
			endcase
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					nx_q    <= scols;
					ny_q    <= srows;
					rx_q    <= '0;
					ry_q    <= '0;
					cnt_q   <= 4'(DIM_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					rx_q  <= gex ? dfx[DIM_W-1:0] : tx[DIM_W-1:0];
					ry_q  <= gey ? dfy[DIM_W-1:0] : ty[DIM_W-1:0];
					nx_q  <= {nx_q[DIM_W-2:0], gex};
					ny_q  <= {ny_q[DIM_W-2:0], gey};
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == '0) begin
						state_q <= S_QUOT;
					end
				end
				S_QUOT: begin
					// a zero icon size gives empty blocks
					bw_q    <= (icols == '0) ? '0 : nx_q;
					bh_q    <= (irows == '0) ? '0 : ny_q;
					state_q <= S_MULX;
				end
				S_MULX: begin
					lim_x_q <= prod_x[DIM_W-1:0];
					state_q <= S_MULY;
				end
				S_MULY: begin
					lim_y_q <= prod_y[DIM_W-1:0];
					state_q <= S_MULA;
				end
				S_MULA: begin
					area_q  <= prod_a[AREA_W-1:0];
					state_q <= S_READY;
				end
				S_READY: ;
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_comb begin
		geom.scols = scols;
		geom.srows = srows;
		geom.icols = icols;
		geom.irows = irows;
		geom.bw    = bw_q;
		geom.bh    = bh_q;
		geom.lim_x = lim_x_q;
		geom.lim_y = lim_y_q;
		geom.area  = area_q;
	end

	assign geom_ok = (state_q == S_READY);

endmodule

// ----- design/bad_front.sv -----
module bad_front import bad_pkg::*; #(
	parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     in_pixel,
	input  logic                 in_frame_start,
	input  geom_t                geom,
	input  logic                 geom_ok,
	input  logic [LVL_W-1:0]     q_level,
	output logic                 push,
	output logic [SUM_WIDTH-1:0] push_sum,
	output blk_tag_t             push_tag
);

	// Raster and block counters
	logic [POS_W-1:0] sx_q, sy_q, ibx_q, iby_q, icy_q;
	logic [COL_W-1:0] icx_q;

	// Column sums, valid bits cleared at frame start and frame end
	logic [SUM_WIDTH-1:0]        mem [MAX_ICON_COLUMNS];
	logic [MAX_ICON_COLUMNS-1:0] vld_q;

	// Accumulate stage
	logic                 s1_valid_q;
	logic                 acc_s1, emit_s1, end_s1, hit_s1, rdv_s1;
	logic [COL_W-1:0]     addr_s1;
	logic [PIX_W-1:0]     pix_s1;
	logic [SUM_WIDTH-1:0] rd_s1, fwd_s1;
	blk_tag_t             tag_s1;

	logic                 in_acc, pend, clr, wr_en;
	logic [LVL_W:0]       need;
	logic [POS_W-1:0]     e_sx, e_sy, e_ibx, e_iby, e_icy;
	logic [COL_W-1:0]     e_icx;
	logic [DIM_W-1:0]     sx_inc, sy_inc, ibx_inc, iby_inc, icy_inc;
	logic [ICW_W-1:0]     icx_inc;
	logic                 row_end, frame_end, blk_x_end, blk_y_end;
	logic                 in_range, emit, last_blk;
	logic [POS_W-1:0]     n_sx, n_sy, n_ibx, n_iby, n_icy;
	logic [COL_W-1:0]     n_icx;
	logic [SUM_WIDTH-1:0] base, sum_new, wr_data;

	// Stall when the queue could not take a result of this item
	assign pend     = s1_valid_q && emit_s1;
	assign need     = {1'b0, q_level} + {{LVL_W{1'b0}}, pend};
	assign in_ready = geom_ok && (need < (LVL_W+1)'(Q_DEPTH));
	assign in_acc   = in_valid && in_ready;

	// Classify the item against the counters, frame start clears them first
	always_comb begin
		e_sx  = in_frame_start ? '0 : sx_q;
		e_sy  = in_frame_start ? '0 : sy_q;
		e_ibx = in_frame_start ? '0 : ibx_q;
		e_iby = in_frame_start ? '0 : iby_q;
		e_icx = in_frame_start ? '0 : icx_q;
		e_icy = in_frame_start ? '0 : icy_q;

		sx_inc  = {1'b0, e_sx} + DIM_W'(1);
		sy_inc  = {1'b0, e_sy} + DIM_W'(1);
		ibx_inc = {1'b0, e_ibx} + DIM_W'(1);
		iby_inc = {1'b0, e_iby} + DIM_W'(1);
		icy_inc = {1'b0, e_icy} + DIM_W'(1);
		icx_inc = {1'b0, e_icx} + ICW_W'(1);

		row_end   = sx_inc >= geom.scols;
		frame_end = row_end && (sy_inc >= geom.srows);
		blk_x_end = ibx_inc >= geom.bw;
		blk_y_end = iby_inc >= geom.bh;

		in_range = (geom.bw != '0) && (geom.bh != '0)
			&& ({1'b0, e_sx} < geom.lim_x) && ({1'b0, e_sy} < geom.lim_y)
			&& ({1'b0, e_icx} < geom.icols) && ({1'b0, e_icy} < geom.irows);
		emit     = in_range && blk_x_end && blk_y_end;
		last_blk = (icx_inc >= geom.icols) && (icy_inc >= geom.irows);
	end

	// Advance the raster position
	always_comb begin
		n_sx  = e_sx;
		n_sy  = e_sy;
		n_ibx = e_ibx;
		n_iby = e_iby;
		n_icx = e_icx;
		n_icy = e_icy;
		if (row_end) begin
			n_sx  = '0;
			n_ibx = '0;
			n_icx = '0;
			if (frame_end) begin
				n_sy  = '0;
				n_iby = '0;
				n_icy = '0;
			end else begin
				n_sy = sy_inc[POS_W-1:0];
				if (blk_y_end) begin
					n_iby = '0;
					if (icy_inc < geom.irows) begin
						n_icy = icy_inc[POS_W-1:0];
					end
				end else begin
					n_iby = iby_inc[POS_W-1:0];
				end
			end
		end else begin
			n_sx = sx_inc[POS_W-1:0];
			if (blk_x_end) begin
				n_ibx = '0;
				if (icx_inc < geom.icols) begin
					n_icx = icx_inc[COL_W-1:0];
				end
			end else begin
				n_ibx = ibx_inc[POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q       <= '0;
			sy_q       <= '0;
			ibx_q      <= '0;
			iby_q      <= '0;
			icx_q      <= '0;
			icy_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_acc;
			if (in_acc) begin
				sx_q  <= n_sx;
				sy_q  <= n_sy;
				ibx_q <= n_ibx;
				iby_q <= n_iby;
				icx_q <= n_icx;
				icy_q <= n_icy;
			end
		end
	end

	// Add the pixel to its column sum, forward a write from the item before
	assign base    = hit_s1 ? fwd_s1 : (rdv_s1 ? rd_s1 : '0);
	assign sum_new = base + SUM_WIDTH'(pix_s1);
	assign wr_data = emit_s1 ? '0 : sum_new;
	assign wr_en   = s1_valid_q && acc_s1 && !end_s1;
	assign clr     = (in_acc && in_frame_start) || (s1_valid_q && end_s1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= wr_data;
		end
		if (in_acc) begin
			rd_s1   <= mem[e_icx];
			rdv_s1  <= vld_q[e_icx] && !clr;
			hit_s1  <= wr_en && (addr_s1 == e_icx) && !in_frame_start;
			fwd_s1  <= wr_data;
			acc_s1  <= in_range;
			emit_s1 <= emit;
			end_s1  <= frame_end;
			addr_s1 <= e_icx;
			pix_s1  <= in_pixel;
			tag_s1  <= '{done: last_blk, col: e_icx, row: e_icy};
		end
	end

	// Drop all sums at once; clearing wins over a write in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[addr_s1] <= 1'b1;
		end
	end

	assign push     = pend;
	assign push_sum = sum_new;
	assign push_tag = tag_s1;

endmodule

// ----- design/bad_queue.sv -----
module bad_queue import bad_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic [LVL_W-1:0] level
);

	localparam int PTR_W = $clog2(Q_DEPTH);

	logic [WIDTH-1:0] slot_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	assign head  = slot_q[rd_ptr_q];
	assign level = level_q;

endmodule

// ----- design/bad_back.sv -----
module bad_back import bad_pkg::*; #(
	parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [LVL_W-1:0]           q_level,
	input  logic [SUM_WIDTH+TAG_W-1:0] q_head,
	output logic                       q_pop,
	input  logic [AREA_W-1:0]          area,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [PIX_W-1:0]           out_mean,
	output blk_tag_t                   out_tag
);

	localparam int CNT_W = $clog2(SUM_WIDTH);

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_HOLD
	} state_t;

	state_t               state_q;
	logic [SUM_WIDTH-1:0] dvd_q;
	logic [AREA_W-1:0]    rem_q;
	logic [PIX_W-1:0]     quo_q;
	logic [CNT_W-1:0]     cnt_q;
	blk_tag_t             tag_q;
	logic                 out_valid_q;
	logic [PIX_W-1:0]     out_mean_q;
	blk_tag_t             out_tag_q;

	logic [AREA_W:0]      t, diff;
	logic                 ge;
	logic                 load_out;

	// One restoring division step; only the low quotient bits are kept
	always_comb begin
		t    = {rem_q, dvd_q[SUM_WIDTH-1]};
		ge   = t >= {1'b0, area};
		diff = t - {1'b0, area};
	end

	assign q_pop    = (state_q == B_IDLE) && (q_level != '0);
	assign load_out = (state_q == B_HOLD) && (!out_valid_q || out_ready);

	// Take a sum from the queue, divide by the block area, hold the mean
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			dvd_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			tag_q       <= '0;
			out_valid_q <= 1'b0;
			out_mean_q  <= '0;
			out_tag_q   <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						dvd_q   <= q_head[TAG_W +: SUM_WIDTH];
						tag_q   <= q_head[TAG_W-1:0];
						rem_q   <= '0;
						quo_q   <= '0;
						cnt_q   <= CNT_W'(SUM_WIDTH - 1);
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					rem_q <= ge ? diff[AREA_W-1:0] : t[AREA_W-1:0];
					dvd_q <= {dvd_q[SUM_WIDTH-2:0], 1'b0};
					quo_q <= {quo_q[PIX_W-2:0], ge};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= B_HOLD;
					end
				end
				B_HOLD: begin
					if (load_out) begin
						out_mean_q <= quo_q;
						out_tag_q  <= tag_q;
						state_q    <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_mean  = out_mean_q;
	assign out_tag   = out_tag_q;

endmodule

// ----- design/block_average_downscale.sv -----
// Block average downscaler: 8-bit pixels in raster order come in on s_axis (tuser marks
// the first pixel of a frame) and each block of (source_columns / icon_columns) by
// (source_rows / icon_rows) pixels leaves as one mean on m_axis, tagged with its icon row
// and column, tlast on the last block of the frame. A pixel is taken every clock while
// s_axis_tready is high; one running sum per icon column lives in a 256-entry memory
// with a read-add-write per pixel. A pixel that closes a block hands its sum through a
// four-entry queue to a bit-serial divider, which takes a new sum only after its last
// mean has gone to the output register, so with small blocks s_axis_tready drops while
// the queue has no room for another sum. After reset and after each configuration write,
// s_axis_tready stays low while the block sizes are derived, while configuration writes
// are always taken.
`include "block_average_downscale_assert.svh"

module block_average_downscale import bad_pkg::*; #(
	parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [7:0] pixel_value
	input  logic                 s_axis_tuser,   // [0] frame_start
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,   // [7:0] block_mean, [19:8] out_row,
	                                             // [27:20] out_column, [31:28] zero
	output logic                 m_axis_tlast,   // frame_done
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	geom_t                      geom;
	logic                       geom_ok;
	logic [LVL_W-1:0]           q_level;
	logic                       q_push, q_pop;
	logic [SUM_WIDTH-1:0]       push_sum;
	blk_tag_t                   push_tag;
	logic [SUM_WIDTH+TAG_W-1:0] q_head;
	logic [PIX_W-1:0]           out_mean;
	blk_tag_t                   out_tag;

	assign cfg_ready = 1'b1;

	// Hold configuration and derive block geometry
	bad_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.geom_ok   (geom_ok)
	);

	// Accept pixels, keep column sums, flag finished blocks
	bad_front #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_pixel       (s_axis_tdata),
		.in_frame_start (s_axis_tuser),
		.geom           (geom),
		.geom_ok        (geom_ok),
		.q_level        (q_level),
		.push           (q_push),
		.push_sum       (push_sum),
		.push_tag       (push_tag)
	);

	// Buffer finished block sums
	bad_queue #(
		.WIDTH (SUM_WIDTH + TAG_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_sum, push_tag}),
		.pop       (q_pop),
		.head      (q_head),
		.level     (q_level)
	);

	// Divide sums by block area and present means
	bad_back #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_level   (q_level),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.area      (geom.area),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_mean  (out_mean),
		.out_tag   (out_tag)
	);

	assign m_axis_tdata = {4'b0000, out_tag.col, out_tag.row, out_mean};
	assign m_axis_tlast = out_tag.done;

	// Pixels only enter once the geometry is derived
	`BAD_ASSERT_IMPLY(a_accept_geom_ok, clk, arst_n, s_axis_tvalid && s_axis_tready, geom_ok)
	// The queue never overflows
	`BAD_ASSERT_IMPLY(a_push_has_room, clk, arst_n, q_push, q_level < LVL_W'(Q_DEPTH))
	// The back end never pops an empty queue
	`BAD_ASSERT_IMPLY(a_pop_not_empty, clk, arst_n, q_pop, q_level != '0)
	// A push without a pop leaves the queue non-empty
	`BAD_ASSERT_NEXT(a_push_fills, clk, arst_n, q_push && !q_pop, q_level != '0)

endmodule
